// File: rtl/ddm_pkg.sv
// ============================================================================
// Decimal digit multiplier package
// Shared sizes and the control structures that pass between the modules.
// ============================================================================
package ddm_pkg;

    localparam int MAX_DIGITS = 32;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int COL_W      = $clog2(2 * MAX_DIGITS);

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic run;
        logic clr;
    } t_cell_ctrl;

    typedef struct packed {
        logic             we;
        logic [COL_W-1:0] addr;
        logic [3:0]       data;
    } t_col_wr;

    typedef struct packed {
        logic             start;
        logic [COL_W-1:0] top;
    } t_emit_req;

endpackage

// File: rtl/decimal_digit_multiplier_top.sv
// ============================================================================
// Decimal digit multiplier
// Schoolbook multiplication of two decimal numbers on a row of digit cells.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. It carries
// one digit, most significant first: i_op low appends to the first number,
// i_op high to the second. A digit above nine is stored as nine. Digits beyond
// the store depth are dropped and the whole product is then flagged too_long.
// A digit request leaves busy low.
// The second number's digit with i_last high starts the product. The first
// number sits in the cell row with its least significant digit in cell zero;
// the second number's digits are fed to all cells, least significant first,
// and one product column leaves cell zero per cycle, n + m columns in all for
// operands of n and m digits. The column store is read through a register;
// the product digits then follow on o_strobe, one per cycle, most significant
// first and without leading zeros; o_last_res marks column zero. busy falls
// after the last digit; the receiver cannot stall.
// Reset is synchronous and empties both numbers.
// ============================================================================
module decimal_digit_multiplier_top
    import ddm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_op,
    input  logic [3:0] i_digit,
    input  logic       i_last,
    output logic       o_strobe,
    output logic [3:0] o_product_digit,
    output logic       o_last_res,
    output logic       o_too_long
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MULT = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_first_cnt;
    logic [CNT_W-1:0] r_second_cnt;
    logic             r_overflow;
    logic             r_too_long;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] r_last_col;
    logic [COL_W-1:0] r_top;
    logic [COL_W-1:0] n_top;
    logic [CNT_W-1:0] n_second_cnt;
    logic [CNT_W:0]   w_col_sum;
    logic             w_accept;
    logic             w_first_full;
    logic             w_second_full;
    logic             w_mult_end;
    logic [3:0]       w_digit;
    t_cell_ctrl       w_ctrl;
    t_col_wr          w_wr;
    t_emit_req        w_req;
    logic             w_emit_strobe;
    logic             w_emit_last;

    logic [3:0] w_a   [MAX_DIGITS];
    logic [3:0] w_b   [MAX_DIGITS];
    logic [3:0] w_dig [MAX_DIGITS];

    assign busy          = (r_state != S_IDLE);
    assign w_accept      = start && !busy;
    assign w_digit       = (i_digit > 4'd9) ? 4'd9 : i_digit;
    assign w_first_full  = (r_first_cnt == MAX_CNT);
    assign w_second_full = (r_second_cnt == MAX_CNT);
    assign n_second_cnt  = w_second_full ? r_second_cnt : r_second_cnt + 1'b1;
    assign w_col_sum     = {1'b0, r_first_cnt} + {1'b0, n_second_cnt} - 1'b1;
    assign w_mult_end    = (r_state == S_MULT) && (r_col == r_last_col);
    assign n_top         = (w_dig[0] != 4'd0) ? r_col : r_top;

    always_comb begin
        w_ctrl.load_a = w_accept && !i_op && !w_first_full;
        w_ctrl.load_b = w_accept && i_op && !w_second_full;
        w_ctrl.run    = (r_state == S_MULT);
        w_ctrl.clr    = w_mult_end;
        w_wr.we       = (r_state == S_MULT);
        w_wr.addr     = r_col;
        w_wr.data     = w_dig[0];
        w_req.start   = w_mult_end;
        w_req.top     = n_top;
    end

    for (genvar j = 0; j < MAX_DIGITS; j++) begin : g_cell
        logic [3:0] w_a_prev;
        logic [3:0] w_b_prev;
        logic [3:0] w_b_next;
        logic [3:0] w_dig_next;

        if (j == 0) begin : g_low
            assign w_a_prev = w_digit;
            assign w_b_prev = w_digit;
        end else begin : g_mid
            assign w_a_prev = w_a[j-1];
            assign w_b_prev = w_b[j-1];
        end

        if (j == MAX_DIGITS - 1) begin : g_high
            assign w_b_next   = 4'd0;
            assign w_dig_next = 4'd0;
        end else begin : g_below
            assign w_b_next   = w_b[j+1];
            assign w_dig_next = w_dig[j+1];
        end

        ddm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_a_prev   (w_a_prev),
            .i_b_prev   (w_b_prev),
            .i_b_next   (w_b_next),
            .i_dig_next (w_dig_next),
            .i_b_bcast  (w_b[0]),
            .o_a        (w_a[j]),
            .o_b        (w_b[j]),
            .o_dig      (w_dig[j])
        );
    end

    ddm_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_req    (w_req),
        .o_strobe (w_emit_strobe),
        .o_digit  (o_product_digit),
        .o_last   (w_emit_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_overflow   <= 1'b0;
            r_too_long   <= 1'b0;
            r_col        <= '0;
            r_last_col   <= '0;
            r_top        <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!i_op) begin
                            if (w_first_full) begin
                                r_overflow <= 1'b1;
                            end else begin
                                r_first_cnt <= r_first_cnt + 1'b1;
                            end
                        end else begin
                            if (w_second_full) begin
                                r_overflow <= 1'b1;
                            end
                            r_second_cnt <= n_second_cnt;
                            if (i_last) begin
                                r_state    <= S_MULT;
                                r_col      <= '0;
                                r_top      <= '0;
                                r_last_col <= w_col_sum[COL_W-1:0];
                            end
                        end
                    end
                end
                S_MULT: begin
                    r_top <= n_top;
                    r_col <= r_col + 1'b1;
                    if (w_mult_end) begin
                        r_state      <= S_EMIT;
                        r_too_long   <= r_overflow;
                        r_overflow   <= 1'b0;
                        r_first_cnt  <= '0;
                        r_second_cnt <= '0;
                    end
                end
                S_EMIT: begin
                    if (w_emit_strobe && w_emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe   = w_emit_strobe;
    assign o_last_res = w_emit_last;
    assign o_too_long = r_too_long;

endmodule

// File: rtl/ddm_cell.sv
// ============================================================================
// Multiplier cell
// Holds one digit of each operand, one partial sum digit and one carry.
// In a run cycle it adds its digit product to the sum, keeps the carry and
// hands the sum digit down to its lower neighbor.
// ============================================================================
module ddm_cell
    import ddm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic [3:0] i_a_prev,
    input  logic [3:0] i_b_prev,
    input  logic [3:0] i_b_next,
    input  logic [3:0] i_dig_next,
    input  logic [3:0] i_b_bcast,
    output logic [3:0] o_a,
    output logic [3:0] o_b,
    output logic [3:0] o_dig
);

    logic [3:0]  r_a;
    logic [3:0]  r_b;
    logic [3:0]  r_s;
    logic [3:0]  r_c;
    logic [7:0]  w_prod;
    logic [6:0]  w_t;
    logic [14:0] w_mul;
    logic [3:0]  w_q;
    logic [6:0]  w_rem;

    // Division by ten of a value below one hundred through a reciprocal.
    assign w_prod = r_a * i_b_bcast;
    assign w_t    = {3'b000, r_s} + w_prod[6:0] + {3'b000, r_c};
    assign w_mul  = {8'b0, w_t} * 15'd205;
    assign w_q    = w_mul[14:11];
    assign w_rem  = w_t - 7'(w_q) * 7'd10;

    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_dig = w_rem[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_s <= '0;
            r_c <= '0;
        end else begin
            priority if (i_ctrl.clr) begin
                r_a <= '0;
                r_b <= '0;
                r_s <= '0;
                r_c <= '0;
            end else if (i_ctrl.run) begin
                r_b <= i_b_next;
                r_s <= i_dig_next;
                r_c <= w_q;
            end else begin
                if (i_ctrl.load_a) begin
                    r_a <= i_a_prev;
                end
                if (i_ctrl.load_b) begin
                    r_b <= i_b_prev;
                end
            end
        end
    end

endmodule

// File: rtl/ddm_emit.sv
// ============================================================================
// Product column store and readout
// Stores the product columns as they leave the cell row and plays them back
// from the top nonzero column down to column zero, one per cycle.
// ============================================================================
module ddm_emit
    import ddm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_col_wr    i_wr,
    input  t_emit_req  i_req,
    output logic       o_strobe,
    output logic [3:0] o_digit,
    output logic       o_last
);

    logic [3:0]       r_mem [2*MAX_DIGITS];
    logic [COL_W-1:0] r_rd_addr;
    logic             r_active;
    logic [3:0]       r_rd_data;
    logic             r_vld;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_vld     <= 1'b0;
            r_last    <= 1'b0;
            r_rd_addr <= '0;
        end else begin
            r_vld  <= r_active;
            r_last <= r_active && (r_rd_addr == '0);
            if (i_req.start) begin
                r_active  <= 1'b1;
                r_rd_addr <= i_req.top;
            end else if (r_active) begin
                if (r_rd_addr == '0) begin
                    r_active <= 1'b0;
                end else begin
                    r_rd_addr <= r_rd_addr - 1'b1;
                end
            end
        end
    end

    assign o_strobe = r_vld;
    assign o_digit  = r_rd_data;
    assign o_last   = r_last;

endmodule

// File: rtl/ddm_checker.sv
// ============================================================================
// Decimal digit multiplier port checker
// Watches the top level's ports for request and result ordering.
// ============================================================================
module ddm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_op,
    input logic       i_last,
    input logic       o_strobe,
    input logic [3:0] o_product_digit,
    input logic       o_last_res
);

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_product_digit <= 4'd9))
        else $error("Product digit above nine.");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("Result shown while the block is idle.");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !(i_op && i_last)) |=> !busy)
        else $error("A digit request without a product start made the block busy.");

    a_product_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op && i_last) |=> (busy && !o_strobe))
        else $error("Product start did not begin the multiply.");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_res) |=> (!o_strobe && !busy))
        else $error("Results continued after the least significant digit.");

endmodule

bind decimal_digit_multiplier_top ddm_checker u_ddm_checker (.*);
